>>> hw/rtl/awsg_pkg.sv
// Shared types, constants and ROM builders for the additive waveform sample generator.
package awsg_pkg;

    // Field and register widths
    localparam int PHASE_W   = 16;
    localparam int SAMPLE_W  = 18;
    localparam int MODE_W    = 2;
    localparam int HCOUNT_W  = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    // Harmonic and table sizing
    localparam int MAX_HARMONICS   = 64;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_QUARTER    = 1 << SINE_TABLE_BITS;
    localparam int SINE_IDX_W      = SINE_TABLE_BITS + 1;
    localparam int SINE_W          = 16;
    localparam int RECIP_DEPTH     = 2 * MAX_HARMONICS;
    localparam int K_W             = $clog2(RECIP_DEPTH);
    localparam int REMAIN_W        = $clog2(MAX_HARMONICS + 1);
    localparam int RECIP_W         = 25;
    localparam int RECIP_FRAC      = 24;

    // Datapath widths
    localparam int MAG_PROD_W = SINE_W + RECIP_W;
    localparam int TERM_W     = MAG_PROD_W + 1;
    localparam int ACC_W      = TERM_W + $clog2(MAX_HARMONICS) + 1;
    localparam int Q24_W      = ACC_W - 15;
    localparam int COEF_W     = 32;
    localparam int PROD_W     = Q24_W + COEF_W;
    localparam int SCALED_W   = PROD_W - 39;

    localparam int SAMPLE_MAX = 131071;
    localparam int SAMPLE_MIN = -131072;

    // Scale factors in Q30
    localparam logic signed [COEF_W-1:0] COEF_SQUARE = 32'sd1367130551;
    localparam logic signed [COEF_W-1:0] COEF_SAW    = -32'sd683565275;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // Waveform select codes
    typedef enum logic [MODE_W-1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_TRI    = 2'd1,
        WAVE_SQUARE = 2'd2,
        WAVE_SAW    = 2'd3
    } t_wave_mode;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HCOUNT = 2'd1;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SINE,
        S_ISSUE,
        S_DRAIN,
        S_SCALE,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       issue;
        logic       scale;
        logic       out_load;
        t_wave_mode mode;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_active;
    } t_dp_status;

    typedef logic [SINE_W-1:0]  t_sine_rom  [0:SINE_QUARTER];
    typedef logic [RECIP_W-1:0] t_recip_rom [0:RECIP_DEPTH-1];

    // Quarter-wave sine, Q15, from a fixed-point Taylor series over [0, pi/2]
    function automatic t_sine_rom f_build_sine_rom();
        t_sine_rom         rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   sum;
        for (int i = 0; i <= SINE_QUARTER; i++) begin
            x    = (HALF_PI_Q30 * longint'(i)) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= 12; k++) begin
                term = (term * x2) >> 30;
                term = term / TAYLOR_DIV[k-1];
                if ((k % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            rom[i] = SINE_W'((sum * 64'd32768 + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

    // Reciprocals 1/k in Q24, rounded half up, by shift-subtract division
    function automatic t_recip_rom f_build_recip_rom();
        t_recip_rom      rom;
        longint unsigned num;
        longint unsigned rem;
        longint unsigned quo;
        rom[0] = '0;
        for (int i = 1; i < RECIP_DEPTH; i++) begin
            num = (64'd1 << RECIP_FRAC) + (longint'(i) >> 1);
            rem = 0;
            quo = 0;
            for (int b = RECIP_FRAC + 1; b >= 0; b--) begin
                rem = (rem << 1) | ((num >> b) & 64'd1);
                quo = quo << 1;
                if (rem >= longint'(i)) begin
                    rem = rem - longint'(i);
                    quo = quo | 64'd1;
                end
            end
            rom[i] = RECIP_W'(quo);
        end
        return rom;
    endfunction

endpackage

>>> hw/rtl/additive_waveform_sample_generator.sv
// Additive waveform sample generator top level: controller plus datapath.
// One phase in, one 18-bit sample out, strobed by o_valid for one cycle.
// Sine: S_SINE then S_DONE; triangle: S_DONE; square/sawtooth: S_DRAIN, S_SCALE, S_DONE,
// after S_ISSUE unless no terms; S_ISSUE takes N = harmonic count clipped to 64,
// one harmonic per cycle through the sine ROM port and the term multiplier.
// busy falls as the strobe rises; a new start is taken then. Sync active-low reset.
module additive_waveform_sample_generator
    import awsg_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [PHASE_W-1:0]         i_phase,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencing and configuration
    awsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_valid    (o_valid)
    );

    // arithmetic
    awsg_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_phase  (i_phase),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_sample (o_sample)
    );

endmodule

>>> hw/rtl/awsg_ctrl.sv
// Controller: configuration registers, harmonic counter and sequencing state machine.
module awsg_ctrl
    import awsg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_status            i_status,
    output t_dp_cmd               o_cmd,
    output logic                  o_valid
);

    t_state               r_state;
    t_state               n_state;
    t_wave_mode           r_mode;
    logic [HCOUNT_W-1:0]  r_hcount;
    logic [REMAIN_W-1:0]  r_remain;
    logic [REMAIN_W-1:0]  n_remain;
    logic                 r_out_valid;
    logic [REMAIN_W-1:0]  w_cap;

    // harmonic count clipped to the supported maximum
    assign w_cap = (int'(r_hcount) > MAX_HARMONICS) ? REMAIN_W'(MAX_HARMONICS)
                                                    : REMAIN_W'(r_hcount);

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= WAVE_SINE;
            r_hcount <= HCOUNT_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:   r_mode   <= t_wave_mode'(i_cfg_data[MODE_W-1:0]);
                CFG_HCOUNT: r_hcount <= i_cfg_data[HCOUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (r_mode)
                        WAVE_SINE: n_state = S_SINE;
                        WAVE_TRI:  n_state = S_DONE;
                        WAVE_SQUARE, WAVE_SAW: begin
                            n_state = (w_cap == '0) ? S_DRAIN : S_ISSUE;
                        end
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SINE:  n_state = S_DONE;
            S_ISSUE: begin
                if (r_remain == REMAIN_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_active) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.mode     = r_mode;
        o_cmd.load     = (r_state == S_IDLE) && start;
        o_cmd.issue    = (r_state == S_ISSUE) || (r_state == S_SINE);
        o_cmd.scale    = (r_state == S_SCALE);
        o_cmd.out_load = (r_state == S_DONE);
    end

    // harmonic countdown
    always_comb begin
        n_remain = r_remain;
        if (o_cmd.load) begin
            n_remain = w_cap;
        end else if (r_state == S_ISSUE) begin
            n_remain = r_remain - REMAIN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_remain    <= n_remain;
            r_out_valid <= o_cmd.out_load;
        end
    end

    // the sample strobe lasts a single cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("sample strobe held longer than one cycle");

    // issuing only happens with harmonics left
    a_issue_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> (r_remain != '0))
        else $error("harmonic issued with zero remaining");

    // scaling only after every term reached the accumulator
    a_scale_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE) |-> !i_status.pipe_active)
        else $error("scale started with terms still in flight");

    // finishing always produces a strobe
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_out_valid)
        else $error("done state without sample strobe");

endmodule

>>> hw/rtl/awsg_datapath.sv
// Datapath: harmonic phase stepping, sine/reciprocal ROMs, term pipeline, scaling and output.
module awsg_datapath
    import awsg_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [PHASE_W-1:0]         i_phase,
    input  t_dp_cmd                    i_cmd,
    output t_dp_status                 o_status,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    localparam t_sine_rom  SINE_ROM  = f_build_sine_rom();
    localparam t_recip_rom RECIP_ROM = f_build_recip_rom();

    localparam logic signed [ACC_W-1:0]    ACC_HALF  = ACC_W'(1) <<< 14;
    localparam logic signed [PROD_W-1:0]   PROD_HALF = PROD_W'(1) <<< 38;
    localparam logic signed [SCALED_W-1:0] SAT_HI    = SCALED_W'(SAMPLE_MAX);
    localparam logic signed [SCALED_W-1:0] SAT_LO    = SCALED_W'(SAMPLE_MIN);

    logic [PHASE_W-1:0]         r_phase;
    logic [PHASE_W-1:0]         r_hphase;
    logic [PHASE_W-1:0]         r_step;
    logic [K_W-1:0]             r_k;
    logic [K_W-1:0]             r_kstep;
    logic                       r_saw;

    logic                       r_s1_valid;
    logic [SINE_W-1:0]          r_s1_mag;
    logic                       r_s1_qneg;
    logic                       r_s1_tneg;
    logic [RECIP_W-1:0]         r_s1_recip;

    logic                       r_s2_valid;
    logic signed [TERM_W-1:0]   r_s2_term;

    logic signed [ACC_W-1:0]    r_acc;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SAMPLE_W-1:0] r_sample;

    logic [1:0]                 w_quad;
    logic [SINE_IDX_W-1:0]      w_idx_raw;
    logic [SINE_IDX_W-1:0]      w_idx;
    logic [MAG_PROD_W-1:0]      w_mag_prod;
    logic signed [TERM_W-1:0]   w_term_pos;
    logic signed [ACC_W-1:0]    w_acc_rnd;
    logic signed [Q24_W-1:0]    w_q24;
    logic signed [COEF_W-1:0]   w_coef;
    logic signed [PROD_W-1:0]   w_prod_rnd;
    logic signed [SCALED_W-1:0] w_scaled;
    logic signed [SAMPLE_W-1:0] w_harm;
    logic signed [SAMPLE_W-1:0] w_sine;
    logic [PHASE_W-1:0]         w_tri_d;
    logic signed [PHASE_W:0]    w_tri_c;
    logic [PHASE_W:0]           w_tri_abs;
    logic signed [SAMPLE_W-1:0] w_tri;
    logic signed [SAMPLE_W-1:0] w_out;

    assign o_status.pipe_active = r_s1_valid | r_s2_valid;
    assign o_sample             = r_sample;

    // quarter-wave addressing of the current harmonic phase
    assign w_quad    = r_hphase[PHASE_W-1 -: 2];
    assign w_idx_raw = {1'b0, r_hphase[PHASE_W-3 -: SINE_TABLE_BITS]};
    assign w_idx     = w_quad[0] ? (SINE_IDX_W'(SINE_QUARTER) - w_idx_raw) : w_idx_raw;

    // harmonic phase and index stepping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_phase  <= i_phase;
            r_hphase <= i_phase;
            r_k      <= K_W'(1);
            r_saw    <= (i_cmd.mode == WAVE_SAW);
            if (i_cmd.mode == WAVE_SQUARE) begin
                r_step  <= {i_phase[PHASE_W-2:0], 1'b0};
                r_kstep <= K_W'(2);
            end else begin
                r_step  <= i_phase;
                r_kstep <= K_W'(1);
            end
        end else if (i_cmd.issue) begin
            r_hphase <= r_hphase + r_step;
            r_k      <= r_k + r_kstep;
        end
    end

    // stage 1: ROM reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_s1_mag   <= SINE_ROM[w_idx];
            r_s1_qneg  <= w_quad[1];
            r_s1_tneg  <= w_quad[1] ^ (r_saw & r_k[0]);
            r_s1_recip <= RECIP_ROM[r_k];
        end
    end

    // stage 2: term = sine * 1/k
    assign w_mag_prod = MAG_PROD_W'(r_s1_mag) * MAG_PROD_W'(r_s1_recip);
    assign w_term_pos = $signed({1'b0, w_mag_prod});

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_term <= r_s1_tneg ? -w_term_pos : w_term_pos;
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
        end
    end

    // term accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (r_s2_valid) begin
            r_acc <= r_acc + ACC_W'(r_s2_term);
        end
    end

    // round the sum to Q24 and scale by the series coefficient
    assign w_acc_rnd = r_acc + ACC_HALF;
    assign w_q24     = w_acc_rnd[ACC_W-1:15];
    assign w_coef    = r_saw ? COEF_SAW : COEF_SQUARE;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_prod <= PROD_W'(w_q24) * PROD_W'(w_coef);
        end
    end

    // round to Q15 and saturate
    assign w_prod_rnd = r_prod + PROD_HALF;
    assign w_scaled   = w_prod_rnd[PROD_W-1:39];

    always_comb begin
        if (w_scaled > SAT_HI) begin
            w_harm = SAMPLE_W'(SAMPLE_MAX);
        end else if (w_scaled < SAT_LO) begin
            w_harm = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            w_harm = SAMPLE_W'(w_scaled);
        end
    end

    // direct sine from the first ROM read
    assign w_sine = r_s1_qneg ? -$signed({2'b00, r_s1_mag}) : $signed({2'b00, r_s1_mag});

    // triangle: 4*|d - 1/2| - 1 in Q15 with d the phase shifted back a quarter turn
    assign w_tri_d   = r_phase - PHASE_W'(16384);
    assign w_tri_c   = $signed({1'b0, w_tri_d}) - (PHASE_W+1)'(32768);
    assign w_tri_abs = w_tri_c[PHASE_W] ? (PHASE_W+1)'(-w_tri_c) : (PHASE_W+1)'(w_tri_c);
    assign w_tri     = $signed({w_tri_abs, 1'b0}) - SAMPLE_W'(32768);

    // output select
    always_comb begin
        case (i_cmd.mode)
            WAVE_SINE: w_out = w_sine;
            WAVE_TRI:  w_out = w_tri;
            default:   w_out = w_harm;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_sample <= w_out;
        end
    end

endmodule
